>>> hw/rtl/ppc_pkg.sv
// Shared types, constants and helper functions for the planar pose compose block.
// No dependencies.
package ppc_pkg;

  localparam logic signed [15:0] ANG_PI      = 16'sd12868;
  localparam logic signed [15:0] ANG_TWO_PI  = 16'sd25736;
  localparam logic signed [15:0] ANG_HALF_PI = 16'sd6434;
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

  // Items carried alongside the rotation.
  typedef struct packed {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [14:0] theta;
    logic               flip;
  } ppc_side_t;

  // CORDIC vector, Q1.30 components and Q3.28 residual angle.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } ppc_vec_t;

  function automatic logic signed [31:0] ppc_atan(input logic [4:0] idx);
    logic signed [31:0] r;
    unique case (idx)
      5'd0:    r = 32'sd210828714;
      5'd1:    r = 32'sd124459457;
      5'd2:    r = 32'sd65760959;
      5'd3:    r = 32'sd33381290;
      5'd4:    r = 32'sd16755422;
      5'd5:    r = 32'sd8385879;
      5'd6:    r = 32'sd4193963;
      5'd7:    r = 32'sd2097109;
      5'd8:    r = 32'sd1048571;
      5'd9:    r = 32'sd524287;
      5'd10:   r = 32'sd262144;
      5'd11:   r = 32'sd131072;
      5'd12:   r = 32'sd65536;
      5'd13:   r = 32'sd32768;
      5'd14:   r = 32'sd16384;
      5'd15:   r = 32'sd8192;
      5'd16:   r = 32'sd4096;
      5'd17:   r = 32'sd2048;
      5'd18:   r = 32'sd1024;
      5'd19:   r = 32'sd512;
      5'd20:   r = 32'sd256;
      5'd21:   r = 32'sd128;
      5'd22:   r = 32'sd64;
      5'd23:   r = 32'sd32;
      5'd24:   r = 32'sd16;
      5'd25:   r = 32'sd8;
      5'd26:   r = 32'sd4;
      5'd27:   r = 32'sd2;
      5'd28:   r = 32'sd1;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

  // Single wrap by two pi.
  function automatic logic signed [15:0] ppc_wrap(input logic signed [15:0] a);
    logic signed [15:0] r;
    r = a;
    if (r > ANG_PI) r = r - ANG_TWO_PI;
    if (r < -ANG_PI) r = r + ANG_TWO_PI;
    return r;
  endfunction

endpackage

>>> hw/rtl/planar_pose_compose.sv
// Planar pose composition: rotates a motion by the reference heading, adds the
// reference position and the heading change. Top level; depends on ppc_pkg,
// ppc_cordic_cell and ppc_combine.
//
// Input channel (in_valid / in_stall) takes one item: reference pose and motion.
// Output channel (out_valid / out_stall) gives one item per input: composed
// position (Q15.16, clipped, with the saturated flag) and heading (Q2.12,
// wrapped once into [-pi, pi]).
// The path is registered after angle reduction, in one cell per CORDIC step,
// then in the multiply, sum and round/clip registers.
// Throughput is one item per cycle while out_stall is low; CORDIC cells are fully pipelined.
// Each stage holds its item only while the stage after it is full and stalled,
// so empty stages keep filling while out_stall is high; in_stall rises once
// every stage is occupied.
// Reset clears all valid flags; no items are in flight afterwards.
module planar_pose_compose import ppc_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] ref_x,
  input  logic signed [31:0] ref_y,
  input  logic signed [14:0] ref_theta,
  input  logic signed [31:0] delta_x,
  input  logic signed [31:0] delta_y,
  input  logic signed [14:0] delta_theta,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [14:0] out_theta,
  output logic               saturated
);

  logic      valid [0:CORDIC_STAGES];
  logic      stall [0:CORDIC_STAGES];
  ppc_vec_t  vec   [0:CORDIC_STAGES];
  ppc_side_t side  [0:CORDIC_STAGES];

  logic signed [15:0] hsum;
  logic signed [15:0] hwrap;
  logic signed [15:0] rwrap;
  logic signed [15:0] fold;
  ppc_vec_t           vec_next;
  ppc_side_t          side_next;

  // angle reduction
  always_comb begin
    hsum  = {ref_theta[14], ref_theta} + {delta_theta[14], delta_theta};
    hwrap = ppc_wrap(hsum);
    rwrap = ppc_wrap({ref_theta[14], ref_theta});
    side_next.rx    = ref_x;
    side_next.ry    = ref_y;
    side_next.dx    = delta_x;
    side_next.dy    = delta_y;
    side_next.theta = hwrap[14:0];
    priority if (rwrap > ANG_HALF_PI) begin
      fold           = rwrap - ANG_PI;
      side_next.flip = 1'b1;
    end else if (rwrap < -ANG_HALF_PI) begin
      fold           = rwrap + ANG_PI;
      side_next.flip = 1'b1;
    end else begin
      fold           = rwrap;
      side_next.flip = 1'b0;
    end
    vec_next.x = CORDIC_GAIN;
    vec_next.y = 32'sd0;
    vec_next.z = {fold, 16'b0};
  end

  assign in_stall = valid[0] && stall[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (!in_stall) begin
      valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      vec[0]  <= vec_next;
      side[0] <= side_next;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    ppc_cordic_cell #(
      .STAGE(i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (valid[i]),
      .up_stall (stall[i]),
      .up_vec   (vec[i]),
      .up_side  (side[i]),
      .dn_valid (valid[i+1]),
      .dn_stall (stall[i+1]),
      .dn_vec   (vec[i+1]),
      .dn_side  (side[i+1])
    );
  end

  ppc_combine u_combine (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (valid[CORDIC_STAGES]),
    .up_stall  (stall[CORDIC_STAGES]),
    .up_vec    (vec[CORDIC_STAGES]),
    .up_side   (side[CORDIC_STAGES]),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_theta (out_theta),
    .saturated (saturated)
  );

endmodule

>>> hw/rtl/ppc_cordic_cell.sv
// One CORDIC rotation step with its pipeline register.
// Depends on ppc_pkg.
module ppc_cordic_cell import ppc_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      up_valid,
  output logic      up_stall,
  input  ppc_vec_t  up_vec,
  input  ppc_side_t up_side,
  output logic      dn_valid,
  input  logic      dn_stall,
  output ppc_vec_t  dn_vec,
  output ppc_side_t dn_side
);

  ppc_vec_t           vec_next;
  logic signed [31:0] sh_x;
  logic signed [31:0] sh_y;
  logic signed [31:0] atan;

  assign up_stall = dn_valid && dn_stall;

  always_comb begin
    sh_x = up_vec.x >>> STAGE;
    sh_y = up_vec.y >>> STAGE;
    atan = ppc_atan(5'(STAGE));
    if (!up_vec.z[31]) begin
      vec_next.x = up_vec.x - sh_y;
      vec_next.y = up_vec.y + sh_x;
      vec_next.z = up_vec.z - atan;
    end else begin
      vec_next.x = up_vec.x + sh_y;
      vec_next.y = up_vec.y - sh_x;
      vec_next.z = up_vec.z + atan;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (!up_stall) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall && up_valid) begin
      dn_vec  <= vec_next;
      dn_side <= up_side;
    end
  end

endmodule

>>> hw/rtl/ppc_combine.sv
// Rotation of the motion, addition of the reference position, rounding and saturation.
// Three registered stages: multiply, sum, round/clip. Depends on ppc_pkg.
module ppc_combine import ppc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  output logic               up_stall,
  input  ppc_vec_t           up_vec,
  input  ppc_side_t          up_side,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [14:0] out_theta,
  output logic               saturated
);

  localparam logic signed [35:0] POS_MAX = 36'sd2147483647;
  localparam logic signed [35:0] POS_MIN = -36'sd2147483648;

  // multiply stage
  logic               m_valid;
  logic               m_stall;
  logic signed [31:0] cs;
  logic signed [31:0] sn;
  logic signed [63:0] p_cdx;
  logic signed [63:0] p_sdy;
  logic signed [63:0] p_sdx;
  logic signed [63:0] p_cdy;
  logic signed [31:0] m_rx;
  logic signed [31:0] m_ry;
  logic signed [14:0] m_theta;

  // sum stage
  logic               a_valid;
  logic               a_stall;
  logic signed [65:0] acc_x;
  logic signed [65:0] acc_y;
  logic signed [14:0] a_theta;

  // round and clip
  logic               f_stall;
  logic signed [65:0] rnd_x;
  logic signed [65:0] rnd_y;
  logic signed [35:0] r_x;
  logic signed [35:0] r_y;
  logic signed [31:0] x_next;
  logic signed [31:0] y_next;
  logic               sat_next;

  assign f_stall  = out_valid && out_stall;
  assign a_stall  = a_valid && f_stall;
  assign m_stall  = m_valid && a_stall;
  assign up_stall = m_stall;

  always_comb begin
    cs = up_side.flip ? -up_vec.x : up_vec.x;
    sn = up_side.flip ? -up_vec.y : up_vec.y;
  end

  always_comb begin
    rnd_x    = acc_x + (66'sd1 <<< 29);
    rnd_y    = acc_y + (66'sd1 <<< 29);
    r_x      = 36'(rnd_x >>> 30);
    r_y      = 36'(rnd_y >>> 30);
    sat_next = 1'b0;
    priority if (r_x > POS_MAX) begin
      x_next   = POS_MAX[31:0];
      sat_next = 1'b1;
    end else if (r_x < POS_MIN) begin
      x_next   = POS_MIN[31:0];
      sat_next = 1'b1;
    end else begin
      x_next = r_x[31:0];
    end
    priority if (r_y > POS_MAX) begin
      y_next   = POS_MAX[31:0];
      sat_next = 1'b1;
    end else if (r_y < POS_MIN) begin
      y_next   = POS_MIN[31:0];
      sat_next = 1'b1;
    end else begin
      y_next = r_y[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid   <= 1'b0;
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!m_stall) m_valid <= up_valid;
      if (!a_stall) a_valid <= m_valid;
      if (!f_stall) out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_stall && up_valid) begin
      p_cdx   <= cs * up_side.dx;
      p_sdy   <= sn * up_side.dy;
      p_sdx   <= sn * up_side.dx;
      p_cdy   <= cs * up_side.dy;
      m_rx    <= up_side.rx;
      m_ry    <= up_side.ry;
      m_theta <= up_side.theta;
    end
    if (!a_stall && m_valid) begin
      acc_x   <= 66'(p_cdx) - 66'(p_sdy) + (66'(m_rx) <<< 30);
      acc_y   <= 66'(p_sdx) + 66'(p_cdy) + (66'(m_ry) <<< 30);
      a_theta <= m_theta;
    end
    if (!f_stall && a_valid) begin
      out_x     <= x_next;
      out_y     <= y_next;
      out_theta <= a_theta;
      saturated <= sat_next;
    end
  end

endmodule
